[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared shorthands for the concurrent checks of the allocator
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BA_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define BA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[sv/ba_pkg.sv]
// ----------------------------------------------------------------------------
// ba_pkg
// types, constants and helpers of the buddy allocator
// ----------------------------------------------------------------------------
`default_nettype none

package ba_pkg;

   localparam int TOTAL_ORDER  = 16;
   localparam int MIN_ORDER    = 5;
   localparam int HEADER_BYTES = 24;

   localparam int UNIT_BITS  = TOTAL_ORDER - MIN_ORDER;
   localparam int UNITS      = 1 << UNIT_BITS;
   localparam int NLISTS     = TOTAL_ORDER;
   localparam int LIST_BITS  = $clog2(NLISTS);
   localparam int ORDER_BITS = $clog2(TOTAL_ORDER + 2);
   localparam int SIZE_BITS  = 17;
   localparam int ADDR_BITS  = 16;
   localparam int TOTAL_BITS = TOTAL_ORDER + 2;
   localparam longint REGION = 64'd1 << TOTAL_ORDER;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_ZERO   = 2'd1;
   localparam logic [1:0] ST_BIG    = 2'd2;
   localparam logic [1:0] ST_NOFREE = 2'd3;

   typedef logic [UNIT_BITS-1:0]  unit_type;
   typedef logic [ORDER_BITS-1:0] order_type;
   typedef logic [LIST_BITS-1:0]  list_type;

   typedef struct packed {
      logic      reserved;
      order_type order;
      unit_type  next;
      unit_type  prev;
   } mem_word_type;

   typedef struct packed {
      logic         rd_en;
      unit_type     rd_addr;
      unit_type     wr_addr;
      logic         we_res;
      logic         we_ord;
      logic         we_next;
      logic         we_prev;
      mem_word_type wr_data;
   } mem_req_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] addr;
      logic [1:0]           status;
   } result_type;

   // free list slot of an order; out of range maps to the top list
   function automatic list_type lidx(input order_type o);
      list_type r;
      if (o >= order_type'(1) && o <= order_type'(NLISTS)) begin
         r = LIST_BITS'(o - order_type'(1));
      end else begin
         r = LIST_BITS'(NLISTS - 1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[sv/ba_req_if.sv]
// ----------------------------------------------------------------------------
// ba_req_if
// request channel: allocate or release beats
// ----------------------------------------------------------------------------
`default_nettype none

interface ba_req_if import ba_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 op;
   logic [SIZE_BITS-1:0] req_size;
   logic [ADDR_BITS-1:0] user_address;

   modport source (output valid, op, req_size, user_address, input ready);
   modport sink   (input valid, op, req_size, user_address, output ready);
endinterface

`default_nettype wire

[sv/ba_rsp_if.sv]
// ----------------------------------------------------------------------------
// ba_rsp_if
// response channel: one beat per request
// ----------------------------------------------------------------------------
`default_nettype none

interface ba_rsp_if import ba_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ADDR_BITS-1:0] result_address;
   logic [1:0]           status;

   modport source (output valid, result_address, status, input ready);
   modport sink   (input valid, result_address, status, output ready);
endinterface

`default_nettype wire

[sv/buddy_allocator.sv]
// ----------------------------------------------------------------------------
// buddy_allocator
// buddy allocator over a 64 KiB region of 32-byte units
// ----------------------------------------------------------------------------
//  port      dir   beat carries
//  req_bus   in    op, req_size, user_address
//  rsp_bus   out   result_address, status
//
//  one request at a time; release is ignored in silence on a bad address
//  allocate: size rounding, list search, then one split per level (table port bound)
//  release: a reserved check, then one merge per level, then a list push
//  after reset a clearing pass over every unit of the table runs before the first request
//  a response waiting in the output register does not hold off new requests
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_allocator import ba_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   ba_req_if.sink    req_bus,
   ba_rsp_if.source  rsp_bus
);

   mem_req_type  mem_req;
   mem_word_type mem_rd;
   logic         res_valid, res_take;
   result_type   res;

   logic         out_valid_ff, out_valid_in;
   result_type   out_ff, out_in;

   ba_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .mem_rd  (mem_rd)
   );

   ba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res       (res),
      .mem_req   (mem_req),
      .mem_rd    (mem_rd)
   );

   // output register frees up when its beat is taken
   assign res_take = !out_valid_ff || rsp_bus.ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
      if (res_valid && res_take) begin
         out_valid_in = 1'b1;
         out_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.result_address = out_ff.addr;
   assign rsp_bus.status         = out_ff.status;

endmodule

`default_nettype wire

[sv/ba_mem.sv]
// ----------------------------------------------------------------------------
// ba_mem
// per-unit table: reserved flag, order and ring links, field write enables
// ----------------------------------------------------------------------------
`default_nettype none

module ba_mem import ba_pkg::*; (
   input  wire logic         clock,
   input  wire mem_req_type  mem_req,
   output mem_word_type      mem_rd
);

   logic      res_mem [UNITS];
   order_type ord_mem [UNITS];
   unit_type  nxt_mem [UNITS];
   unit_type  prv_mem [UNITS];

   always_ff @(posedge clock) begin
      if (mem_req.we_res) begin
         res_mem[mem_req.wr_addr] <= mem_req.wr_data.reserved;
      end
      if (mem_req.we_ord) begin
         ord_mem[mem_req.wr_addr] <= mem_req.wr_data.order;
      end
      if (mem_req.we_next) begin
         nxt_mem[mem_req.wr_addr] <= mem_req.wr_data.next;
      end
      if (mem_req.we_prev) begin
         prv_mem[mem_req.wr_addr] <= mem_req.wr_data.prev;
      end
      mem_rd.reserved <= res_mem[mem_req.rd_addr];
      mem_rd.order    <= ord_mem[mem_req.rd_addr];
      mem_rd.next     <= nxt_mem[mem_req.rd_addr];
      mem_rd.prev     <= prv_mem[mem_req.rd_addr];
   end

endmodule

`default_nettype wire

[sv/ba_ctrl.sv]
// ----------------------------------------------------------------------------
// ba_ctrl
// sequencer: size rounding, list search, split, merge and list upkeep
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ba_ctrl import ba_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   ba_req_if.sink            req_bus,
   output logic              res_valid,
   input  wire logic         res_take,
   output result_type        res,
   output mem_req_type       mem_req,
   input  wire mem_word_type mem_rd
);

   localparam logic [4:0] S_CLEAR  = 5'd0;
   localparam logic [4:0] S_IDLE   = 5'd1;
   localparam logic [4:0] S_DONE   = 5'd2;
   localparam logic [4:0] A_K      = 5'd3;
   localparam logic [4:0] A_J      = 5'd4;
   localparam logic [4:0] A_LOOP   = 5'd5;
   localparam logic [4:0] A_SPLIT  = 5'd6;
   localparam logic [4:0] A_SPLIT2 = 5'd7;
   localparam logic [4:0] A_SPLIT3 = 5'd8;
   localparam logic [4:0] A_FIN    = 5'd9;
   localparam logic [4:0] R_ISSUE  = 5'd10;
   localparam logic [4:0] R_CHK    = 5'd11;
   localparam logic [4:0] R_LOOP   = 5'd12;
   localparam logic [4:0] R_BCHK   = 5'd13;
   localparam logic [4:0] R_MERGE  = 5'd14;
   localparam logic [4:0] R_END    = 5'd15;
   localparam logic [4:0] T_RD     = 5'd16;
   localparam logic [4:0] T_DAT    = 5'd17;
   localparam logic [4:0] T_W2     = 5'd18;
   localparam logic [4:0] T_SELF   = 5'd19;
   localparam logic [4:0] P_ST     = 5'd20;
   localparam logic [4:0] P_DAT    = 5'd21;
   localparam logic [4:0] P_W2     = 5'd22;
   localparam logic [4:0] P_W3     = 5'd23;

   logic [4:0]            state_ff, state_in, ret_ff, ret_in;
   unit_type              u_ff, u_in, b_ff, b_in, n_ff, n_in, p_ff, p_in, h_ff, h_in;
   unit_type              pu_ff, pu_in, clr_ff, clr_in;
   order_type             k_ff, k_in, j_ff, j_in, pk_ff, pk_in;
   logic [TOTAL_BITS-1:0] total_ff, total_in;
   unit_type              head_ff [NLISTS];
   unit_type              head_in [NLISTS];
   logic [NLISTS-1:0]     nonempty_ff, nonempty_in;
   result_type            res_ff, res_in;

   logic [TOTAL_BITS-1:0] sum_w;
   logic [ADDR_BITS-1:0]  start_w;
   list_type              li_w;
   unit_type              nu_w;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign res_valid     = (state_ff == S_DONE);
   assign res           = res_ff;

   assign sum_w   = TOTAL_BITS'(req_bus.req_size) + TOTAL_BITS'(HEADER_BYTES);
   assign start_w = req_bus.user_address - ADDR_BITS'(HEADER_BYTES);
   assign li_w    = lidx(pk_ff);
   assign nu_w    = (b_ff < u_ff) ? b_ff : u_ff;

   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      u_in        = u_ff;
      b_in        = b_ff;
      n_in        = n_ff;
      p_in        = p_ff;
      h_in        = h_ff;
      pu_in       = pu_ff;
      pk_in       = pk_ff;
      k_in        = k_ff;
      j_in        = j_ff;
      clr_in      = clr_ff;
      total_in    = total_ff;
      head_in     = head_ff;
      nonempty_in = nonempty_ff;
      res_in      = res_ff;
      mem_req     = '0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_req.wr_addr = clr_ff;
            mem_req.we_res  = 1'b1;
            mem_req.we_ord  = 1'b1;
            mem_req.we_next = 1'b1;
            mem_req.we_prev = 1'b1;
            mem_req.wr_data.order = (clr_ff == '0) ? order_type'(TOTAL_ORDER) : '0;
            clr_in = clr_ff + unit_type'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_bus.valid) begin
               res_in.addr   = '0;
               res_in.status = ST_OK;
               state_in      = S_DONE;
               if (req_bus.op == OP_ALLOC) begin
                  if (req_bus.req_size == '0) begin
                     res_in.status = ST_ZERO;
                  end else if (sum_w > TOTAL_BITS'(REGION)) begin
                     res_in.status = ST_BIG;
                  end else begin
                     total_in = sum_w;
                     k_in     = order_type'(MIN_ORDER);
                     state_in = A_K;
                  end
               end else if (req_bus.user_address >= ADDR_BITS'(HEADER_BYTES) &&
                            start_w[MIN_ORDER-1:0] == '0) begin
                  u_in     = start_w[ADDR_BITS-1:MIN_ORDER];
                  state_in = R_ISSUE;
               end
            end
         end
         A_K: begin
            if (k_ff < order_type'(TOTAL_ORDER) &&
                (TOTAL_BITS'(1) << k_ff) < total_ff) begin
               k_in = k_ff + order_type'(1);
            end else begin
               j_in     = k_ff;
               state_in = A_J;
            end
         end
         A_J: begin
            if (j_ff > order_type'(TOTAL_ORDER)) begin
               res_in.status = ST_NOFREE;
               state_in      = S_DONE;
            end else if (!nonempty_ff[lidx(j_ff)]) begin
               j_in = j_ff + order_type'(1);
            end else begin
               u_in     = head_ff[lidx(j_ff)];
               state_in = A_LOOP;
            end
         end
         A_LOOP: begin
            pu_in    = u_ff;
            state_in = T_RD;
            if (j_ff > k_ff) begin
               pk_in  = j_ff;
               ret_in = A_SPLIT;
            end else begin
               pk_in  = k_ff;
               ret_in = A_FIN;
            end
         end
         A_SPLIT: begin
            j_in = j_ff - order_type'(1);
            b_in = u_ff + (unit_type'(1) << (j_ff - order_type'(MIN_ORDER + 1)));
            mem_req.wr_addr       = u_ff;
            mem_req.we_ord        = 1'b1;
            mem_req.wr_data.order = j_ff - order_type'(1);
            state_in = A_SPLIT2;
         end
         A_SPLIT2: begin
            mem_req.wr_addr       = b_ff;
            mem_req.we_ord        = 1'b1;
            mem_req.we_res        = 1'b1;
            mem_req.wr_data.order = j_ff;
            pu_in    = b_ff;
            pk_in    = j_ff;
            ret_in   = A_SPLIT3;
            state_in = P_ST;
         end
         A_SPLIT3: begin
            pu_in    = u_ff;
            pk_in    = j_ff;
            ret_in   = A_LOOP;
            state_in = P_ST;
         end
         A_FIN: begin
            mem_req.wr_addr          = u_ff;
            mem_req.we_ord           = 1'b1;
            mem_req.we_res           = 1'b1;
            mem_req.wr_data.order    = k_ff;
            mem_req.wr_data.reserved = 1'b1;
            res_in.addr = {u_ff, {MIN_ORDER{1'b0}}} + ADDR_BITS'(HEADER_BYTES);
            state_in    = S_DONE;
         end
         R_ISSUE: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = u_ff;
            state_in        = R_CHK;
         end
         R_CHK: begin
            if (!mem_rd.reserved) begin
               state_in = S_DONE;
            end else begin
               mem_req.wr_addr = u_ff;
               mem_req.we_res  = 1'b1;
               if (mem_rd.order < order_type'(MIN_ORDER) ||
                   mem_rd.order > order_type'(TOTAL_ORDER)) begin
                  k_in = order_type'(MIN_ORDER);
               end else begin
                  k_in = mem_rd.order;
               end
               state_in = R_LOOP;
            end
         end
         R_LOOP: begin
            if (k_ff < order_type'(TOTAL_ORDER)) begin
               b_in = u_ff ^ (unit_type'(1) << (k_ff - order_type'(MIN_ORDER)));
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = u_ff ^ (unit_type'(1) << (k_ff - order_type'(MIN_ORDER)));
               state_in = R_BCHK;
            end else begin
               state_in = R_END;
            end
         end
         R_BCHK: begin
            if (mem_rd.reserved || mem_rd.order != k_ff) begin
               state_in = R_END;
            end else begin
               pu_in    = b_ff;
               pk_in    = k_ff;
               ret_in   = R_MERGE;
               state_in = T_RD;
            end
         end
         R_MERGE: begin
            u_in = nu_w;
            k_in = k_ff + order_type'(1);
            mem_req.wr_addr       = nu_w;
            mem_req.we_ord        = 1'b1;
            mem_req.wr_data.order = k_ff + order_type'(1);
            state_in = R_LOOP;
         end
         R_END: begin
            mem_req.wr_addr       = u_ff;
            mem_req.we_ord        = 1'b1;
            mem_req.wr_data.order = k_ff;
            pu_in    = u_ff;
            pk_in    = k_ff;
            ret_in   = S_DONE;
            state_in = P_ST;
         end
         // unlink pu from the ring of order pk
         T_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = pu_ff;
            state_in        = T_DAT;
         end
         T_DAT: begin
            n_in = mem_rd.next;
            p_in = mem_rd.prev;
            if (mem_rd.next == pu_ff) begin
               nonempty_in[li_w] = 1'b0;
               state_in          = T_SELF;
            end else begin
               mem_req.wr_addr      = mem_rd.prev;
               mem_req.we_next      = 1'b1;
               mem_req.wr_data.next = mem_rd.next;
               state_in             = T_W2;
            end
         end
         T_W2: begin
            mem_req.wr_addr      = n_ff;
            mem_req.we_prev      = 1'b1;
            mem_req.wr_data.prev = p_ff;
            if (head_ff[li_w] == pu_ff) begin
               head_in[li_w] = n_ff;
            end
            state_in = T_SELF;
         end
         T_SELF: begin
            mem_req.wr_addr      = pu_ff;
            mem_req.we_next      = 1'b1;
            mem_req.we_prev      = 1'b1;
            mem_req.wr_data.next = pu_ff;
            mem_req.wr_data.prev = pu_ff;
            state_in             = ret_ff;
         end
         // link pu in front of the head of order pk
         P_ST: begin
            if (nonempty_ff[li_w]) begin
               h_in            = head_ff[li_w];
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = head_ff[li_w];
               state_in        = P_DAT;
            end else begin
               mem_req.wr_addr      = pu_ff;
               mem_req.we_next      = 1'b1;
               mem_req.we_prev      = 1'b1;
               mem_req.wr_data.next = pu_ff;
               mem_req.wr_data.prev = pu_ff;
               head_in[li_w]        = pu_ff;
               nonempty_in[li_w]    = 1'b1;
               state_in             = ret_ff;
            end
         end
         P_DAT: begin
            p_in                 = mem_rd.prev;
            mem_req.wr_addr      = mem_rd.prev;
            mem_req.we_next      = 1'b1;
            mem_req.wr_data.next = pu_ff;
            state_in             = P_W2;
         end
         P_W2: begin
            mem_req.wr_addr      = pu_ff;
            mem_req.we_next      = 1'b1;
            mem_req.we_prev      = 1'b1;
            mem_req.wr_data.next = h_ff;
            mem_req.wr_data.prev = p_ff;
            state_in             = P_W3;
         end
         P_W3: begin
            mem_req.wr_addr      = h_ff;
            mem_req.we_prev      = 1'b1;
            mem_req.wr_data.prev = pu_ff;
            head_in[li_w]        = pu_ff;
            nonempty_in[li_w]    = 1'b1;
            state_in             = ret_ff;
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         ret_ff      <= S_DONE;
         clr_ff      <= '0;
         nonempty_ff <= NLISTS'(1) << lidx(order_type'(TOTAL_ORDER));
         for (int i = 0; i < NLISTS; i++) begin
            head_ff[i] <= '0;
         end
      end else begin
         state_ff    <= state_in;
         ret_ff      <= ret_in;
         clr_ff      <= clr_in;
         nonempty_ff <= nonempty_in;
         head_ff     <= head_in;
      end
      u_ff     <= u_in;
      b_ff     <= b_in;
      n_ff     <= n_in;
      p_ff     <= p_in;
      h_ff     <= h_in;
      pu_ff    <= pu_in;
      pk_ff    <= pk_in;
      k_ff     <= k_in;
      j_ff     <= j_in;
      total_ff <= total_in;
      res_ff   <= res_in;
   end

   // reads never share a cycle with a write, so no bypass is needed
   `BA_ASSERT_IMPLY(a_no_rw_overlap, clock, reset, mem_req.rd_en,
      !(mem_req.we_res || mem_req.we_ord || mem_req.we_next || mem_req.we_prev))
   `BA_ASSERT_NEXT(a_accept_leaves_idle, clock, reset,
      req_bus.valid && req_bus.ready, state_ff != S_IDLE)
   `BA_ASSERT_IMPLY(a_fail_null_addr, clock, reset,
      res_valid && res.status != ST_OK, res.addr == '0)

endmodule

`default_nettype wire
